/* rtl/core/nc2d_pkg.sv */
package nc2d_pkg;

    // pipeline depths and datapath widths
    localparam int SQ_STAGES = 32;   // one root bit per stage, 64-bit radicand
    localparam int DV_STAGES = 15;   // one quotient bit per stage, quotient <= 16384
    localparam int NUM_W     = 47;   // |c| * 16384 + dist / 2 fits below 2^46

    localparam logic signed [15:0] Q14_ONE = 16'sd16384;
    localparam logic signed [15:0] Q14_NEG = -16'sd16384;

    // pair classification
    typedef enum logic [1:0] {
        MODE_CC,    // circle vs circle
        MODE_BB,    // box vs box
        MODE_CB,    // A circle, B box
        MODE_BC     // A box, B circle (solved as circle-box, normal flipped)
    } t_mode;

    typedef struct packed {
        logic               is_box;
        logic signed [30:0] px;
        logic signed [30:0] py;
        logic [29:0]        sx;
        logic [29:0]        sy;
    } t_shape;

    // sideband that rides along the square-root pipeline
    // direct: result already known (box-box, circle center inside box)
    // nx/ny : direct normal, or the fallback normal for a zero distance
    // pen   : direct depth, or the radius (sum) when a distance is still needed
    typedef struct packed {
        logic               direct;
        logic               hit;
        logic               negx;
        logic               negy;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic [30:0]        pen;
        logic [31:0]        magx;
        logic [31:0]        magy;
    } t_sq_side;

    // sideband that rides along the divider pipeline
    typedef struct packed {
        logic               hit;
        logic               use_q;
        logic               negx;
        logic               negy;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic [30:0]        pen;
    } t_dv_side;

endpackage

/* rtl/core/narrowphase_collision_2d.sv */
// Narrowphase contact test for one pair of 2D bodies (circle or axis-aligned box).
// Input channel: one body pair per beat on i_valid / o_stall, taken at a rising
// edge with i_valid high and o_stall low. Output channel: one contact per beat
// on o_valid / i_stall: hit flag, Q1.14 unit normal from A to B, Q15.16 depth.
// Every input beat gives exactly one output beat, in order; no hit gives zeros.
// The pipeline is four geometry/square stages, a 32-stage square root
// (one root bit per stage), one numerator stage, a 15-stage divider (one
// quotient bit per stage, both normal axes in parallel) and the output register.
// Throughput is one pair per cycle while o_stall is low; the divider and square
// root are fully pipelined, so nothing is shared between beats.
// While the output beat is held by i_stall the whole pipeline freezes and
// o_stall is raised; nothing is dropped or repeated, and bubbles inside the
// pipe are not squeezed out.
// Reset (synchronous, active low) clears all valid bits; the block keeps no
// state between pairs, so it is ready on the first cycle after reset.
module narrowphase_collision_2d (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_a_is_box,
    input  logic signed [30:0]  i_a_pos_x,
    input  logic signed [30:0]  i_a_pos_y,
    input  logic [29:0]         i_a_size_x,
    input  logic [29:0]         i_a_size_y,
    input  logic                i_b_is_box,
    input  logic signed [30:0]  i_b_pos_x,
    input  logic signed [30:0]  i_b_pos_y,
    input  logic [29:0]         i_b_size_x,
    input  logic [29:0]         i_b_size_y,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_hit,
    output logic signed [15:0]  o_normal_x,
    output logic signed [15:0]  o_normal_y,
    output logic [30:0]         o_penetration
);

    localparam int W = nc2d_pkg::NUM_W;

    logic               en;
    nc2d_pkg::t_shape   a_shape, b_shape;

    // global advance: everything moves unless a finished beat is held
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    always_comb begin
        a_shape.is_box = i_a_is_box;
        a_shape.px     = i_a_pos_x;
        a_shape.py     = i_a_pos_y;
        a_shape.sx     = i_a_size_x;
        a_shape.sy     = i_a_size_y;
        b_shape.is_box = i_b_is_box;
        b_shape.px     = i_b_pos_x;
        b_shape.py     = i_b_pos_y;
        b_shape.sx     = i_b_size_x;
        b_shape.sy     = i_b_size_y;
    end

    // geometry and squared distance
    logic               g_valid;
    logic [63:0]        g_d2;
    nc2d_pkg::t_sq_side g_side;

    nc2d_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_a     (a_shape),
        .i_b     (b_shape),
        .o_valid (g_valid),
        .o_d2    (g_d2),
        .o_side  (g_side)
    );

    // distance
    logic               s_valid;
    logic [31:0]        s_root;
    nc2d_pkg::t_sq_side s_side;

    nc2d_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (g_valid),
        .i_rad   (g_d2),
        .i_side  (g_side),
        .o_valid (s_valid),
        .o_root  (s_root),
        .o_side  (s_side)
    );

    // numerator stage: rounded dividends, depth, fallback selection
    logic               r_pv;
    logic [W-1:0]       n_num_x, n_num_y, r_num_x, r_num_y;
    logic [31:0]        r_dist;
    nc2d_pkg::t_dv_side n_dv, r_dv;

    always_comb begin
        n_num_x  = W'({s_side.magx, 14'b0}) + W'(s_root >> 1);
        n_num_y  = W'({s_side.magy, 14'b0}) + W'(s_root >> 1);
        n_dv.hit   = s_side.hit;
        n_dv.use_q = !s_side.direct && (s_root != '0);
        n_dv.negx  = s_side.negx;
        n_dv.negy  = s_side.negy;
        n_dv.nx    = s_side.nx;
        n_dv.ny    = s_side.ny;
        n_dv.pen   = s_side.direct ? s_side.pen : 31'(32'(s_side.pen) - s_root);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (en) begin
            r_pv <= s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_num_x <= n_num_x;
            r_num_y <= n_num_y;
            r_dist  <= s_root;
            r_dv    <= n_dv;
        end
    end

    // normal components
    logic               d_valid;
    logic [14:0]        d_qx, d_qy;
    nc2d_pkg::t_dv_side d_side;

    nc2d_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_pv),
        .i_num_x (r_num_x),
        .i_num_y (r_num_y),
        .i_dist  (r_dist),
        .i_side  (r_dv),
        .o_valid (d_valid),
        .o_qx    (d_qx),
        .o_qy    (d_qy),
        .o_side  (d_side)
    );

    // output stage: clamp, sign, zero on miss
    logic signed [15:0] qx16, qy16;
    logic               n_hit, r_hit, r_ov;
    logic signed [15:0] n_nx, n_ny, r_nx, r_ny;
    logic [30:0]        n_pen, r_pen;

    always_comb begin
        qx16  = (d_qx > 15'd16384) ? nc2d_pkg::Q14_ONE : 16'(d_qx);
        qy16  = (d_qy > 15'd16384) ? nc2d_pkg::Q14_ONE : 16'(d_qy);
        n_hit = d_side.hit;
        n_nx  = '0;
        n_ny  = '0;
        n_pen = '0;
        if (d_side.hit) begin
            n_pen = d_side.pen;
            if (d_side.use_q) begin
                n_nx = d_side.negx ? -qx16 : qx16;
                n_ny = d_side.negy ? -qy16 : qy16;
            end else begin
                n_nx = d_side.nx;
                n_ny = d_side.ny;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit <= n_hit;
            r_nx  <= n_nx;
            r_ny  <= n_ny;
            r_pen <= n_pen;
        end
    end

    assign o_valid       = r_ov;
    assign o_hit         = r_hit;
    assign o_normal_x    = r_nx;
    assign o_normal_y    = r_ny;
    assign o_penetration = r_pen;

endmodule

/* rtl/core/nc2d_geom.sv */
module nc2d_geom (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  nc2d_pkg::t_shape    i_a,
    input  nc2d_pkg::t_shape    i_b,
    output logic                o_valid,
    output logic [63:0]         o_d2,
    output nc2d_pkg::t_sq_side  o_side
);

    logic [3:0] r_v;

    // stage 1: classify the pair, center differences and size sums
    nc2d_pkg::t_mode    n_mode, r_mode;
    logic signed [31:0] n_dx, n_dy, r_dx, r_dy;
    logic [30:0]        n_sx, n_sy, n_r, r_sx, r_sy, r_r;

    always_comb begin
        n_mode = nc2d_pkg::MODE_CC;
        n_dx   = 32'(i_b.px) - 32'(i_a.px);
        n_dy   = 32'(i_b.py) - 32'(i_a.py);
        n_sx   = 31'(i_a.sx) + 31'(i_b.sx);
        n_sy   = 31'(i_a.sy) + 31'(i_b.sy);
        n_r    = n_sx;
        unique case ({i_a.is_box, i_b.is_box})
            2'b00: begin
                n_mode = nc2d_pkg::MODE_CC;
            end
            2'b11: begin
                n_mode = nc2d_pkg::MODE_BB;
            end
            2'b01: begin
                // circle A against box B, offset taken box to circle
                n_mode = nc2d_pkg::MODE_CB;
                n_dx   = 32'(i_a.px) - 32'(i_b.px);
                n_dy   = 32'(i_a.py) - 32'(i_b.py);
                n_sx   = 31'(i_b.sx);
                n_sy   = 31'(i_b.sy);
                n_r    = 31'(i_a.sx);
            end
            default: begin
                n_mode = nc2d_pkg::MODE_BC;
                n_sx   = 31'(i_a.sx);
                n_sy   = 31'(i_a.sy);
                n_r    = 31'(i_b.sx);
            end
        endcase
    end

    // stage 2: overlaps, inside test, clamped offset
    logic [31:0]         adx, ady, ex_x, ex_y;
    logic signed [32:0]  ox, oy;
    logic                in_box;
    logic [30:0]         ipx, ipy;
    logic signed [15:0]  tx, ty;
    nc2d_pkg::t_sq_side  n_s2, r_s2;

    always_comb begin
        adx    = r_dx[31] ? 32'(-r_dx) : 32'(r_dx);
        ady    = r_dy[31] ? 32'(-r_dy) : 32'(r_dy);
        ox     = 33'(r_sx) - 33'(adx);
        oy     = 33'(r_sy) - 33'(ady);
        in_box = (adx <= 32'(r_sx)) && (ady <= 32'(r_sy));
        ipx    = 31'(32'(r_sx) - adx);
        ipy    = 31'(32'(r_sy) - ady);
        ex_x   = (adx > 32'(r_sx)) ? adx - 32'(r_sx) : '0;
        ex_y   = (ady > 32'(r_sy)) ? ady - 32'(r_sy) : '0;
        tx     = '0;
        ty     = '0;

        n_s2.direct = 1'b0;
        n_s2.hit    = 1'b0;
        n_s2.negx   = r_dx[31];
        n_s2.negy   = r_dy[31];
        n_s2.nx     = nc2d_pkg::Q14_ONE;
        n_s2.ny     = '0;
        n_s2.pen    = r_r;
        n_s2.magx   = adx;
        n_s2.magy   = ady;

        unique case (r_mode)
            nc2d_pkg::MODE_CC: begin
                // distance path; coincident centers fall back to +x
            end
            nc2d_pkg::MODE_BB: begin
                n_s2.direct = 1'b1;
                n_s2.hit    = (ox > 0) && (oy > 0);
                if (ox < oy) begin
                    n_s2.nx  = r_dx[31] ? nc2d_pkg::Q14_NEG : nc2d_pkg::Q14_ONE;
                    n_s2.ny  = '0;
                    n_s2.pen = 31'(ox);
                end else begin
                    n_s2.nx  = '0;
                    n_s2.ny  = r_dy[31] ? nc2d_pkg::Q14_NEG : nc2d_pkg::Q14_ONE;
                    n_s2.pen = 31'(oy);
                end
            end
            default: begin
                if (in_box) begin
                    // pop out through the nearest face, tie goes to y
                    n_s2.direct = 1'b1;
                    n_s2.hit    = 1'b1;
                    if (ipx < ipy) begin
                        tx       = r_dx[31] ? nc2d_pkg::Q14_NEG : nc2d_pkg::Q14_ONE;
                        n_s2.pen = r_r + ipx;
                    end else begin
                        ty       = r_dy[31] ? nc2d_pkg::Q14_NEG : nc2d_pkg::Q14_ONE;
                        n_s2.pen = r_r + ipy;
                    end
                    n_s2.nx = (r_mode == nc2d_pkg::MODE_CB) ? -tx : tx;
                    n_s2.ny = (r_mode == nc2d_pkg::MODE_CB) ? -ty : ty;
                end else begin
                    // circle center outside: offset from nearest box point
                    n_s2.magx = ex_x;
                    n_s2.magy = ex_y;
                    n_s2.negx = r_dx[31] ^ (r_mode == nc2d_pkg::MODE_CB);
                    n_s2.negy = r_dy[31] ^ (r_mode == nc2d_pkg::MODE_CB);
                    n_s2.nx   = '0;
                    n_s2.ny   = (r_mode == nc2d_pkg::MODE_CB) ? nc2d_pkg::Q14_ONE
                                                               : nc2d_pkg::Q14_NEG;
                end
            end
        endcase
    end

    // stage 3: squares
    logic [63:0]        n_px2, n_py2, n_r2, r_px2, r_py2, r_r2;
    nc2d_pkg::t_sq_side r_s3;

    always_comb begin
        n_px2 = r_s2.magx * r_s2.magx;
        n_py2 = r_s2.magy * r_s2.magy;
        n_r2  = r_s2.pen * r_s2.pen;
    end

    // stage 4: squared distance against squared radius
    logic [63:0]        n_d2, r_d2;
    nc2d_pkg::t_sq_side n_s4, r_s4;

    always_comb begin
        n_d2 = r_px2 + r_py2;
        n_s4 = r_s3;
        if (!r_s3.direct) begin
            n_s4.hit = n_d2 < r_r2;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mode <= n_mode;
            r_dx   <= n_dx;
            r_dy   <= n_dy;
            r_sx   <= n_sx;
            r_sy   <= n_sy;
            r_r    <= n_r;
            r_s2   <= n_s2;
            r_px2  <= n_px2;
            r_py2  <= n_py2;
            r_r2   <= n_r2;
            r_s3   <= r_s2;
            r_d2   <= n_d2;
            r_s4   <= n_s4;
        end
    end

    assign o_valid = r_v[3];
    assign o_d2    = r_d2;
    assign o_side  = r_s4;

endmodule

/* rtl/core/nc2d_sqrt.sv */
module nc2d_sqrt (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [63:0]         i_rad,
    input  nc2d_pkg::t_sq_side  i_side,
    output logic                o_valid,
    output logic [31:0]         o_root,
    output nc2d_pkg::t_sq_side  o_side
);

    localparam int N = nc2d_pkg::SQ_STAGES;

    logic [N-1:0]       r_v;
    logic [63:0]        in_rem [0:N-1];
    logic [63:0]        in_res [0:N-1];
    logic [63:0]        n_rem  [0:N-1];
    logic [63:0]        n_res  [0:N-1];
    logic [63:0]        r_rem  [0:N-1];
    logic [63:0]        r_res  [0:N-1];
    nc2d_pkg::t_sq_side in_side [0:N-1];
    nc2d_pkg::t_sq_side r_side  [0:N-1];

    // stage inputs
    always_comb begin
        in_rem[0]  = i_rad;
        in_res[0]  = '0;
        in_side[0] = i_side;
        for (int k = 1; k < N; k++) begin
            in_rem[k]  = r_rem[k-1];
            in_res[k]  = r_res[k-1];
            in_side[k] = r_side[k-1];
        end
    end

    // one root bit per stage, trial bit 4^(N-1-k)
    always_comb begin
        for (int k = 0; k < N; k++) begin
            if (in_rem[k] >= in_res[k] + (64'(1) << (2 * (N - 1 - k)))) begin
                n_rem[k] = in_rem[k] - (in_res[k] + (64'(1) << (2 * (N - 1 - k))));
                n_res[k] = (in_res[k] >> 1) + (64'(1) << (2 * (N - 1 - k)));
            end else begin
                n_rem[k] = in_rem[k];
                n_res[k] = in_res[k] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[N-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < N; k++) begin
                r_rem[k]  <= n_rem[k];
                r_res[k]  <= n_res[k];
                r_side[k] <= in_side[k];
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_root  = r_res[N-1][31:0];
    assign o_side  = r_side[N-1];

endmodule

/* rtl/core/nc2d_div.sv */
module nc2d_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [nc2d_pkg::NUM_W-1:0]  i_num_x,
    input  logic [nc2d_pkg::NUM_W-1:0]  i_num_y,
    input  logic [31:0]                 i_dist,
    input  nc2d_pkg::t_dv_side          i_side,
    output logic                        o_valid,
    output logic [14:0]                 o_qx,
    output logic [14:0]                 o_qy,
    output nc2d_pkg::t_dv_side          o_side
);

    localparam int N = nc2d_pkg::DV_STAGES;
    localparam int W = nc2d_pkg::NUM_W;

    logic [N-1:0]       r_v;
    logic [W-1:0]       in_rx [0:N-1];
    logic [W-1:0]       in_ry [0:N-1];
    logic [14:0]        in_qx [0:N-1];
    logic [14:0]        in_qy [0:N-1];
    logic [31:0]        in_d  [0:N-1];
    nc2d_pkg::t_dv_side in_s  [0:N-1];
    logic [W-1:0]       n_rx  [0:N-1];
    logic [W-1:0]       n_ry  [0:N-1];
    logic [14:0]        n_qx  [0:N-1];
    logic [14:0]        n_qy  [0:N-1];
    logic [W-1:0]       dsh   [0:N-1];
    logic [W-1:0]       r_rx  [0:N-1];
    logic [W-1:0]       r_ry  [0:N-1];
    logic [14:0]        r_qx  [0:N-1];
    logic [14:0]        r_qy  [0:N-1];
    logic [31:0]        r_d   [0:N-1];
    nc2d_pkg::t_dv_side r_s   [0:N-1];

    // stage inputs
    always_comb begin
        in_rx[0] = i_num_x;
        in_ry[0] = i_num_y;
        in_qx[0] = '0;
        in_qy[0] = '0;
        in_d[0]  = i_dist;
        in_s[0]  = i_side;
        for (int k = 1; k < N; k++) begin
            in_rx[k] = r_rx[k-1];
            in_ry[k] = r_ry[k-1];
            in_qx[k] = r_qx[k-1];
            in_qy[k] = r_qy[k-1];
            in_d[k]  = r_d[k-1];
            in_s[k]  = r_s[k-1];
        end
    end

    // restoring division, quotient bit N-1-k in stage k, both axes share the divisor
    always_comb begin
        for (int k = 0; k < N; k++) begin
            dsh[k]  = W'(in_d[k]) << (N - 1 - k);
            n_rx[k] = in_rx[k];
            n_ry[k] = in_ry[k];
            n_qx[k] = in_qx[k];
            n_qy[k] = in_qy[k];
            if (in_rx[k] >= dsh[k]) begin
                n_rx[k]          = in_rx[k] - dsh[k];
                n_qx[k][N-1-k]   = 1'b1;
            end
            if (in_ry[k] >= dsh[k]) begin
                n_ry[k]          = in_ry[k] - dsh[k];
                n_qy[k][N-1-k]   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[N-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < N; k++) begin
                r_rx[k] <= n_rx[k];
                r_ry[k] <= n_ry[k];
                r_qx[k] <= n_qx[k];
                r_qy[k] <= n_qy[k];
                r_d[k]  <= in_d[k];
                r_s[k]  <= in_s[k];
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_qx    = r_qx[N-1];
    assign o_qy    = r_qy[N-1];
    assign o_side  = r_s[N-1];

endmodule
